@@ rtl/ir_gesture_mode_selector_core_assert.svh @@
// Assertion macros shared by the IR gesture mode selector RTL.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef IR_GESTURE_MODE_SELECTOR_CORE_ASSERT_SVH
`define IR_GESTURE_MODE_SELECTOR_CORE_ASSERT_SVH

// same-cycle implication
`define IRG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ir gesture assertion failed");

// next-cycle implication
`define IRG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ir gesture assertion failed");

`endif

@@ rtl/ir_gms_pkg.sv @@
// Shared types, constants and helpers for the IR gesture mode selector.
// No dependencies.
package ir_gms_pkg;

  localparam int NUM_LANES   = 4;
  localparam int LEVEL_W     = 12;
  localparam int HOLD_W      = 16;
  localparam int TIME_W      = 32;
  localparam int CODE_W      = 3;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_TIME = 1'd1;

  localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 12'd1000;
  localparam logic [HOLD_W-1:0]  HOLD_TIME_RST = 16'd1000;

  localparam int LANE_LEFT        = 0;
  localparam int LANE_FRONT_LEFT  = 1;
  localparam int LANE_FRONT_RIGHT = 2;
  localparam int LANE_RIGHT       = 3;

  localparam logic [CODE_W-1:0] CODE_IDLE      = 3'd0;
  localparam logic [CODE_W-1:0] CODE_SPEED     = 3'd1;
  localparam logic [CODE_W-1:0] CODE_DISCOVERY = 3'd2;
  localparam logic [CODE_W-1:0] CODE_MEASURE   = 3'd3;
  localparam logic [CODE_W-1:0] CODE_SNAPSHOT  = 3'd4;

  typedef enum logic [4:0] {
    MODE_IDLE      = 5'b00001,
    MODE_SPEED     = 5'b00010,
    MODE_DISCOVERY = 5'b00100,
    MODE_MEASURE   = 5'b01000,
    MODE_SNAPSHOT  = 5'b10000
  } mode_t;

  typedef struct packed {
    logic              force_mode;
    logic              update;
    logic [CODE_W-1:0] new_mode;
  } upd_cmd_t;

  typedef struct packed {
    logic [CODE_W-1:0] mode;
    logic              changed;
  } result_t;

  function automatic logic [CODE_W-1:0] mode_to_code(mode_t m);
    logic [CODE_W-1:0] c;
    unique case (m)
      MODE_IDLE:      c = CODE_IDLE;
      MODE_SPEED:     c = CODE_SPEED;
      MODE_DISCOVERY: c = CODE_DISCOVERY;
      MODE_MEASURE:   c = CODE_MEASURE;
      MODE_SNAPSHOT:  c = CODE_SNAPSHOT;
      default:        c = CODE_IDLE;
    endcase
    return c;
  endfunction

  function automatic mode_t code_to_mode(logic [CODE_W-1:0] c);
    mode_t m;
    unique case (c)
      CODE_IDLE:      m = MODE_IDLE;
      CODE_SPEED:     m = MODE_SPEED;
      CODE_DISCOVERY: m = MODE_DISCOVERY;
      CODE_MEASURE:   m = MODE_MEASURE;
      CODE_SNAPSHOT:  m = MODE_SNAPSHOT;
      default:        m = MODE_IDLE;
    endcase
    return m;
  endfunction

endpackage

@@ rtl/ir_gms_lane.sv @@
// One IR channel qualifier: threshold compare and hold timer.
// Depends on ir_gms_pkg.
module ir_gms_lane
  import ir_gms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               update,
  input  logic [LEVEL_W-1:0] level,
  input  logic [TIME_W-1:0]  now,
  input  logic [LEVEL_W-1:0] threshold,
  input  logic [HOLD_W-1:0]  hold_time,
  output logic               active
);

  logic [TIME_W-1:0] hold_start;
  logic [TIME_W-1:0] hold_start_next;
  logic [TIME_W-1:0] elapsed;
  logic              above;
  logic              timing;

  assign above   = level > threshold;
  assign timing  = hold_start != '0;
  assign elapsed = now - hold_start;
  assign active  = above && timing && (elapsed >= TIME_W'(hold_time));

  always_comb begin
    hold_start_next = hold_start;
    if (update) begin
      if (!above) begin
        hold_start_next = '0;
      end else if (!timing) begin
        hold_start_next = now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_start <= '0;
    end else begin
      hold_start <= hold_start_next;
    end
  end

endmodule

@@ rtl/ir_gms_mode.sv @@
// Merge stage: combines lane activity, ready/changed flags and the mode machine.
// Depends on ir_gms_pkg and the assertion macro header.
`include "ir_gesture_mode_selector_core_assert.svh"

module ir_gms_mode
  import ir_gms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  upd_cmd_t             cmd,
  input  logic [NUM_LANES-1:0] active,
  output result_t              result
);

  mode_t state;
  mode_t state_next;
  logic  ready;
  logic  ready_next;
  logic  changed;
  logic  changed_next;
  logic  l, fl, fr, r, any_act, ready_eff;

  assign l         = active[LANE_LEFT];
  assign fl        = active[LANE_FRONT_LEFT];
  assign fr        = active[LANE_FRONT_RIGHT];
  assign r         = active[LANE_RIGHT];
  assign any_act   = |active;
  assign ready_eff = ready || !any_act;

  always_comb begin
    state_next   = state;
    ready_next   = ready;
    changed_next = changed;
    if (cmd.force_mode) begin
      if (cmd.new_mode <= CODE_SNAPSHOT) begin
        state_next = code_to_mode(cmd.new_mode);
      end
    end else if (cmd.update) begin
      ready_next   = ready_eff;
      changed_next = 1'b0;
      if (ready_eff) begin
        unique case (state)
          MODE_IDLE: begin
            if (l && !r && !fl && !fr) begin
              state_next = MODE_SPEED;
            end else if (!l && r && !fl && !fr) begin
              state_next = MODE_DISCOVERY;
            end
          end
          MODE_SPEED, MODE_DISCOVERY: begin
            if (l && r) begin
              state_next = MODE_IDLE;
            end
          end
          MODE_MEASURE: begin
            if (l && r) begin
              state_next = MODE_IDLE;
            end else if (any_act) begin
              state_next = MODE_SNAPSHOT;
            end
          end
          MODE_SNAPSHOT: begin
            if (!any_act) begin
              state_next = MODE_MEASURE;
            end
          end
          default: state_next = state;
        endcase
        // a step that lands in a different mode clears ready and sets changed
        if (state_next != state) begin
          ready_next   = 1'b0;
          changed_next = 1'b1;
        end
      end
    end
  end

  assign result.mode    = mode_to_code(state_next);
  assign result.changed = changed_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= MODE_IDLE;
      ready   <= 1'b0;
      changed <= 1'b0;
    end else begin
      state   <= state_next;
      ready   <= ready_next;
      changed <= changed_next;
    end
  end

  `IRG_ASSERT_NOW(a_changed_not_ready, changed, !ready)
  `IRG_ASSERT_NEXT(a_force_sets_mode, cmd.force_mode && (cmd.new_mode <= CODE_SNAPSHOT),
                   mode_to_code(state) == $past(cmd.new_mode))
  `IRG_ASSERT_NEXT(a_busy_holds_mode, cmd.update && !ready && any_act, $stable(state))

endmodule

@@ rtl/ir_gesture_mode_selector_core.sv @@
// IR gesture mode selector: top level with config registers and result buffer.
// Depends on ir_gms_pkg, ir_gms_lane, ir_gms_mode and the assertion macro header.
//
// Takes one transaction per clock, back to back, while item_stall is low. Four
// lanes qualify the sensor levels against their registered hold timestamps and
// the merge stage steps the mode machine in the same cycle, so each result is
// written into the output buffer on the edge that accepts its item.
// A two-entry output buffer absorbs downstream stalls; item_stall rises only
// when both entries hold results. Config writes are always taken (cfg_ready
// is tied high) and should only occur while the block is idle.
`include "ir_gesture_mode_selector_core_assert.svh"

module ir_gesture_mode_selector_core
  import ir_gms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  logic                   action,
  input  logic [LEVEL_W-1:0]     left_mv,
  input  logic [LEVEL_W-1:0]     front_left_mv,
  input  logic [LEVEL_W-1:0]     front_right_mv,
  input  logic [LEVEL_W-1:0]     right_mv,
  input  logic [TIME_W-1:0]      now_ms,
  input  logic [CODE_W-1:0]      new_mode,
  output logic                   result_valid,
  input  logic                   result_stall,
  output logic [CODE_W-1:0]      mode,
  output logic                   mode_changed
);

  logic [LEVEL_W-1:0]   threshold;
  logic [HOLD_W-1:0]    hold_time;
  logic [LEVEL_W-1:0]   levels [NUM_LANES];
  logic [NUM_LANES-1:0] active;
  upd_cmd_t             cmd;
  result_t              res_new;
  result_t              head;
  result_t              skid;
  logic                 head_valid;
  logic                 skid_valid;
  logic                 push;
  logic                 pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
      hold_time <= HOLD_TIME_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data[LEVEL_W-1:0];
        CFG_HOLD_TIME: hold_time <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign push = item_valid && !item_stall;
  assign pop  = result_valid && !result_stall;

  assign cmd.force_mode = push && action;
  assign cmd.update     = push && !action;
  assign cmd.new_mode   = new_mode;

  assign levels[LANE_LEFT]        = left_mv;
  assign levels[LANE_FRONT_LEFT]  = front_left_mv;
  assign levels[LANE_FRONT_RIGHT] = front_right_mv;
  assign levels[LANE_RIGHT]       = right_mv;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    ir_gms_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .update    (cmd.update),
      .level     (levels[i]),
      .now       (now_ms),
      .threshold (threshold),
      .hold_time (hold_time),
      .active    (active[i])
    );
  end

  ir_gms_mode u_mode (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .active (active),
    .result (res_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      priority if (push && !pop) begin
        if (!head_valid) begin
          head_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (pop && !push) begin
        head_valid <= skid_valid;
        skid_valid <= 1'b0;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (push && !pop) begin
      if (!head_valid) begin
        head <= res_new;
      end else begin
        skid <= res_new;
      end
    end else if (pop && push) begin
      if (skid_valid) begin
        head <= skid;
        skid <= res_new;
      end else begin
        head <= res_new;
      end
    end else if (pop) begin
      head <= skid;
    end else begin
    end
  end

  assign item_stall   = skid_valid;
  assign result_valid = head_valid;
  assign mode         = head.mode;
  assign mode_changed = head.changed;

  `IRG_ASSERT_NOW(a_skid_needs_head, skid_valid, head_valid)
  `IRG_ASSERT_NEXT(a_fill_to_stall, push && !pop && head_valid, item_stall)
  `IRG_ASSERT_NOW(a_mode_in_range, result_valid, mode <= CODE_SNAPSHOT)

endmodule
